### rtl/ltcp_pkg.sv
// ----------------------------------------------------------------------------
// ltcp_pkg
// Shared constants, types and helper functions for the LED text command
// parser: character codes, match progress codes and the line summary.
// ----------------------------------------------------------------------------
`default_nettype none

package ltcp_pkg;

  // Default parameter values
  localparam int unsigned LineMaxDef   = 64;
  localparam int unsigned MaxTokensDef = 5;
  localparam int unsigned PortWidthDef = 16;

  // Fixed field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 16;
  localparam int unsigned PinW   = 4;
  localparam int unsigned AccW   = 8;

  // Character codes
  localparam logic [ByteW-1:0] CharNul    = 8'h00;
  localparam logic [ByteW-1:0] CharTab    = 8'h09;
  localparam logic [ByteW-1:0] CharCr     = 8'h0d;
  localparam logic [ByteW-1:0] CharSpace  = 8'h20;
  localparam logic [ByteW-1:0] CharPlus   = 8'h2b;
  localparam logic [ByteW-1:0] CharMinus  = 8'h2d;
  localparam logic [ByteW-1:0] CharZero   = 8'h30;
  localparam logic [ByteW-1:0] CharNine   = 8'h39;
  localparam logic [ByteW-1:0] CharAt     = 8'h40;
  localparam logic [ByteW-1:0] CharLBrack = 8'h5b;
  localparam logic [ByteW-1:0] CharRBrack = 8'h5d;
  localparam logic [ByteW-1:0] CharL      = 8'h4c;
  localparam logic [ByteW-1:0] CharE      = 8'h45;
  localparam logic [ByteW-1:0] CharD      = 8'h44;
  localparam logic [ByteW-1:0] CharO      = 8'h4f;
  localparam logic [ByteW-1:0] CharN      = 8'h4e;

  // Keyword match progress codes
  localparam logic [2:0] LedStart = 3'd0;
  localparam logic [2:0] LedDone  = 3'd3;
  localparam logic [2:0] LedFail  = 3'd4;
  localparam logic [1:0] OnStart  = 2'd0;
  localparam logic [1:0] OnDone   = 2'd2;
  localparam logic [1:0] OnFail   = 2'd3;

  // Number parse phases
  localparam logic [1:0] PhLead = 2'd0;
  localparam logic [1:0] PhDig  = 2'd1;
  localparam logic [1:0] PhDone = 2'd2;

  // Saturation limit of the pin number
  localparam logic [AccW-1:0] AccMax = 8'd255;

  // What the command stage needs to know about the finished line
  typedef struct packed {
    logic            led_ok;
    logic            on_ok;
    logic            third_seen;
    logic            num_neg;
    logic [AccW-1:0] num_acc;
  } line_sum_t;

  function automatic logic is_space(input logic [ByteW-1:0] c);
    return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  endfunction

  function automatic logic is_sep(input logic [ByteW-1:0] c);
    return (c == CharLBrack) || (c == CharAt) || (c == CharRBrack);
  endfunction

  function automatic logic [ByteW-1:0] led_char(input logic [1:0] idx);
    logic [ByteW-1:0] ch;
    unique case (idx)
      2'd0:    ch = CharL;
      2'd1:    ch = CharE;
      2'd2:    ch = CharD;
      default: ch = CharNul;
    endcase
    return ch;
  endfunction

  function automatic logic [ByteW-1:0] on_char(input logic idx);
    return idx ? CharN : CharO;
  endfunction

endpackage

`default_nettype wire

### rtl/led_text_command_parser_unit.sv
// ----------------------------------------------------------------------------
// led_text_command_parser_unit
// Top level of the LED text command parser.
// ----------------------------------------------------------------------------
// Takes one received byte per word on the input channel and answers once per
// carriage-return-ended line with the port bits after the line, whether a
// pin was changed, the pin index and the on/off request. A line "x[LED]ON]3"
// style command sets or clears one of PORT_WIDTH port bits. The block takes
// one byte every clock cycle unless a carriage return must wait in the input
// register for the result register; every other byte is parsed in the cycle
// after it is captured in the input register. A line's result word is
// registered in the output register when its carriage return is parsed, and
// other bytes keep flowing while a result waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module led_text_command_parser_unit #(
  parameter int unsigned LINE_MAX   = ltcp_pkg::LineMaxDef,
  parameter int unsigned MAX_TOKENS = ltcp_pkg::MaxTokensDef,
  parameter int unsigned PORT_WIDTH = ltcp_pkg::PortWidthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [ltcp_pkg::ByteW-1:0]    rx_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [ltcp_pkg::ValueW-1:0]        port_value_o,
  output logic                               applied_o,
  output logic [ltcp_pkg::PinW-1:0]          pin_index_o,
  output logic                               turn_on_o
);

  logic                          in_valid_q, in_valid_d;
  logic [ltcp_pkg::ByteW-1:0]    byte_q;
  logic                          is_cr;
  logic                          advance;
  logic                          accept;
  ltcp_pkg::line_sum_t           line_sum;

  // Advance the held byte unless it ends a line and the result slot is busy
  assign is_cr      = (byte_q == ltcp_pkg::CharCr);
  assign advance    = in_valid_q && (!is_cr || !out_valid_o || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Capture the incoming byte
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= rx_byte_i;
    end
  end

  ltcp_line_parser #(
    .LINE_MAX   (LINE_MAX),
    .MAX_TOKENS (MAX_TOKENS)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (byte_q),
    .sum_o  (line_sum)
  );

  ltcp_cmd_exec #(
    .PORT_WIDTH (PORT_WIDTH)
  ) u_exec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (advance && is_cr),
    .sum_i        (line_sum),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .port_value_o (port_value_o),
    .applied_o    (applied_o),
    .pin_index_o  (pin_index_o),
    .turn_on_o    (turn_on_o)
  );

`ifndef SYNTHESIS
  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && is_cr && out_valid_o))
    else $error("input stalled without a waiting line end");
  a_byte_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(byte_q)))
    else $error("held byte lost before it was parsed");
  a_cr_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && is_cr) |=> out_valid_o)
    else $error("line end gave no result");
`endif

endmodule

`default_nettype wire

### rtl/ltcp_line_parser.sv
// ----------------------------------------------------------------------------
// ltcp_line_parser
// Per-line parse state: splits the byte stream into tokens, matches the
// keywords in the second and third tokens and reads the pin number from the fourth.
// ----------------------------------------------------------------------------
`default_nettype none

module ltcp_line_parser #(
  parameter int unsigned LINE_MAX   = ltcp_pkg::LineMaxDef,
  parameter int unsigned MAX_TOKENS = ltcp_pkg::MaxTokensDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire logic [ltcp_pkg::ByteW-1:0]    byte_i,
  output ltcp_pkg::line_sum_t                sum_o
);

  localparam int unsigned LenW = $clog2(LINE_MAX + 1);
  localparam int unsigned TcW  = $clog2(MAX_TOKENS + 2);
  localparam logic [LenW-1:0] LenFull = LenW'(LINE_MAX);
  localparam logic [TcW-1:0]  TcLast  = TcW'(MAX_TOKENS);

  logic [LenW-1:0]              len_q, len_d;
  logic [TcW-1:0]               tc_q, tc_d;
  logic                         inside_q, inside_d;
  logic [2:0]                   led_q, led_d;
  logic [1:0]                   on_q, on_d;
  logic [ltcp_pkg::AccW-1:0]    acc_q, acc_d;
  logic [1:0]                   ph_q, ph_d;
  logic                         neg_q, neg_d;
  logic                         third_q, third_d;

  logic                         take_digit;
  logic                         is_digit;
  logic [11:0]                  acc_next;

  // Digit accumulate: acc * 10 + digit, saturated
  assign is_digit = (byte_i >= ltcp_pkg::CharZero) && (byte_i <= ltcp_pkg::CharNine);
  assign acc_next = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + {8'd0, byte_i[3:0]};

  // Advance the parse state by one byte
  always_comb begin
    len_d      = len_q;
    tc_d       = tc_q;
    inside_d   = inside_q;
    led_d      = led_q;
    on_d       = on_q;
    acc_d      = acc_q;
    ph_d       = ph_q;
    neg_d      = neg_q;
    third_d    = third_q;
    take_digit = 1'b0;
    if (step_i) begin
      if (byte_i == ltcp_pkg::CharCr) begin
        len_d    = '0;
        tc_d     = '0;
        inside_d = 1'b0;
        led_d    = ltcp_pkg::LedStart;
        on_d     = ltcp_pkg::OnStart;
        acc_d    = '0;
        ph_d     = ltcp_pkg::PhLead;
        neg_d    = 1'b0;
        third_d  = 1'b0;
      end else if (len_q < LenFull) begin
        len_d = len_q + LenW'(1);
        priority if (byte_i == ltcp_pkg::CharNul) begin
          len_d    = LenFull;
          inside_d = 1'b0;
        end else if (ltcp_pkg::is_sep(byte_i)) begin
          inside_d = 1'b0;
        end else begin
          // Open a new token
          if (!inside_q) begin
            inside_d = 1'b1;
            if (tc_q <= TcLast) begin
              tc_d = tc_q + TcW'(1);
            end
            if (tc_d == TcW'(4)) begin
              third_d = 1'b1;
            end
          end
          // Feed the byte to the token it belongs to
          priority if (tc_d == TcW'(2)) begin
            if ((led_q < ltcp_pkg::LedDone) && (byte_i == ltcp_pkg::led_char(led_q[1:0])))
            begin
              led_d = led_q + 3'd1;
            end else begin
              led_d = ltcp_pkg::LedFail;
            end
          end else if (tc_d == TcW'(3)) begin
            if ((on_q < ltcp_pkg::OnDone) && (byte_i == ltcp_pkg::on_char(on_q[0]))) begin
              on_d = on_q + 2'd1;
            end else begin
              on_d = ltcp_pkg::OnFail;
            end
          end else if (tc_d == TcW'(4)) begin
            unique case (ph_q)
              ltcp_pkg::PhLead: begin
                if (!ltcp_pkg::is_space(byte_i)) begin
                  ph_d = ltcp_pkg::PhDig;
                  if ((byte_i == ltcp_pkg::CharPlus) || (byte_i == ltcp_pkg::CharMinus)) begin
                    neg_d = (byte_i == ltcp_pkg::CharMinus);
                  end else begin
                    take_digit = 1'b1;
                  end
                end
              end
              ltcp_pkg::PhDig: begin
                take_digit = 1'b1;
              end
              default: begin
              end
            endcase
            if (take_digit) begin
              if (is_digit) begin
                acc_d = (acc_next > 12'(ltcp_pkg::AccMax)) ? ltcp_pkg::AccMax
                                                           : acc_next[7:0];
              end else begin
                ph_d = ltcp_pkg::PhDone;
              end
            end
          end else begin
          end
        end
      end
    end
  end

  // Parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      tc_q     <= '0;
      inside_q <= 1'b0;
      led_q    <= ltcp_pkg::LedStart;
      on_q     <= ltcp_pkg::OnStart;
      acc_q    <= '0;
      ph_q     <= ltcp_pkg::PhLead;
      neg_q    <= 1'b0;
      third_q  <= 1'b0;
    end else begin
      len_q    <= len_d;
      tc_q     <= tc_d;
      inside_q <= inside_d;
      led_q    <= led_d;
      on_q     <= on_d;
      acc_q    <= acc_d;
      ph_q     <= ph_d;
      neg_q    <= neg_d;
      third_q  <= third_d;
    end
  end

  // Summary of the line so far
  assign sum_o.led_ok     = (led_q == ltcp_pkg::LedDone);
  assign sum_o.on_ok      = (on_q == ltcp_pkg::OnDone);
  assign sum_o.third_seen = third_q;
  assign sum_o.num_neg    = neg_q;
  assign sum_o.num_acc    = acc_q;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenFull)
    else $error("line length past its limit");
  a_tc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tc_q <= TcLast + TcW'(1))
    else $error("token count past its limit");
  a_inside_tc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inside_q |-> tc_q != '0)
    else $error("inside a token with no token counted");
`endif

endmodule

`default_nettype wire

### rtl/ltcp_cmd_exec.sv
// ----------------------------------------------------------------------------
// ltcp_cmd_exec
// Applies a finished LED command to the port bits and holds the result word
// in the output register until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ltcp_cmd_exec #(
  parameter int unsigned PORT_WIDTH = ltcp_pkg::PortWidthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          fire_i,
  input  wire ltcp_pkg::line_sum_t           sum_i,
  input  wire logic                          out_stall_i,
  output logic                               out_valid_o,
  output logic [ltcp_pkg::ValueW-1:0]        port_value_o,
  output logic                               applied_o,
  output logic [ltcp_pkg::PinW-1:0]          pin_index_o,
  output logic                               turn_on_o
);

  localparam int unsigned IdxW = $clog2(PORT_WIDTH);
  localparam int unsigned ValW = ltcp_pkg::ValueW;

  logic [PORT_WIDTH-1:0]          port_q, port_d;
  logic                           valid_q, valid_d;
  logic [ltcp_pkg::ValueW-1:0]    value_q;
  logic                           applied_q;
  logic [ltcp_pkg::PinW-1:0]      pin_q;
  logic                           on_q;

  logic [ltcp_pkg::AccW-1:0]      num;
  logic                           neg;
  logic                           hit;
  logic                           turn_on;
  logic [PORT_WIDTH-1:0]          bit_mask;
  logic [ValW-1:0]                port_ext;

  // Decode the command
  assign num      = sum_i.third_seen ? sum_i.num_acc : '0;
  assign neg      = sum_i.third_seen && sum_i.num_neg && (num != '0);
  assign turn_on  = sum_i.led_ok && sum_i.on_ok;
  assign hit      = sum_i.led_ok && !neg && ({1'b0, num} < 9'(PORT_WIDTH));
  assign bit_mask = PORT_WIDTH'(1) << num[IdxW-1:0];

  // Set or clear the addressed bit
  always_comb begin
    port_d = port_q;
    if (fire_i && hit) begin
      port_d = turn_on ? (port_q | bit_mask) : (port_q & ~bit_mask);
    end
  end

  assign port_ext = ValW'(port_d);

  // Hold the result until taken
  always_comb begin
    valid_d = valid_q;
    if (fire_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      port_q  <= port_d;
      valid_q <= valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      value_q   <= port_ext;
      applied_q <= hit;
      pin_q     <= hit ? num[ltcp_pkg::PinW-1:0] : '0;
      on_q      <= turn_on;
    end
  end

  assign out_valid_o  = valid_q;
  assign port_value_o = value_q;
  assign applied_o    = applied_q;
  assign pin_index_o  = pin_q;
  assign turn_on_o    = on_q;

`ifndef SYNTHESIS
  a_port_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fire_i && hit) |=> $stable(port_q))
    else $error("port bits changed without a command");
  a_pin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !applied_q) |-> (pin_q == '0))
    else $error("pin index set on a line that changed nothing");
  a_fire_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i |-> (!valid_q || !out_stall_i))
    else $error("result overwritten before it was taken");
`endif

endmodule

`default_nettype wire

### dv/ltcp_checker.sv
// ----------------------------------------------------------------------------
// ltcp_checker
// Watches both channels of the LED text command parser. It tracks every
// accepted byte with its own parse of the line and the port bits, queues one
// predicted answer per carriage return, and compares each result word
// against the oldest prediction.
// ----------------------------------------------------------------------------
module ltcp_checker
  import ltcp_pkg::*;
#(
  parameter int unsigned LINE_MAX   = LineMaxDef,
  parameter int unsigned MAX_TOKENS = MaxTokensDef,
  parameter int unsigned PORT_WIDTH = PortWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [ByteW-1:0]  rx_byte_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [ValueW-1:0] port_value_i,
  input  logic              applied_i,
  input  logic [PinW-1:0]   pin_index_i,
  input  logic              turn_on_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Token positions, counted from one, that carry the keyword and the pin
  localparam int unsigned LedTok = 2;
  localparam int unsigned OnTok  = 3;
  localparam int unsigned PinTok = 4;

  typedef struct packed {
    logic [ValueW-1:0] port_value;
    logic              applied;
    logic [PinW-1:0]   pin_index;
    logic              turn_on;
  } led_answer_t;

  led_answer_t             port_answer_q[$];
  logic [PORT_WIDTH-1:0]   port_bits = '0;
  int unsigned             tok_cnt = 0;
  logic                    in_tok = 1'b0;
  logic [2:0]              led_prog = LedStart;
  logic [1:0]              on_prog = OnStart;
  int unsigned             pin_acc = 0;
  logic [1:0]              num_phase = PhLead;
  logic                    num_neg = 1'b0;
  logic                    third_seen = 1'b0;
  int unsigned             line_len = 0;

  initial fail_count_o = 0;
  initial pending_o = 0;

  // Drop everything learned about the current line
  task automatic restart_line();
    tok_cnt    = 0;
    in_tok     = 1'b0;
    led_prog   = LedStart;
    on_prog    = OnStart;
    pin_acc    = 0;
    num_phase  = PhLead;
    num_neg    = 1'b0;
    third_seen = 1'b0;
    line_len   = 0;
  endtask

  // Advance the line parse by one byte; a carriage return yields an answer
  task automatic parse_rx_byte(input logic [ByteW-1:0] c);
    led_answer_t      ans;
    logic [ByteW-1:0] want;
    int unsigned      pin;
    logic             neg;
    logic             skip;
    if (c != CharCr) begin
      if (line_len < LINE_MAX) begin
        line_len++;
        if (c == CharNul) begin
          // a zero byte ends the content of the line
          line_len = LINE_MAX;
          in_tok   = 1'b0;
        end else if (c == CharLBrack || c == CharAt || c == CharRBrack) begin
          in_tok = 1'b0;
        end else begin
          if (!in_tok) begin
            in_tok = 1'b1;
            if (tok_cnt <= MAX_TOKENS) tok_cnt++;
            if (tok_cnt == PinTok) third_seen = 1'b1;
          end
          if (tok_cnt == LedTok) begin
            want = (led_prog == 3'd0) ? CharL : (led_prog == 3'd1) ? CharE : CharD;
            if (led_prog < LedDone && c == want) led_prog++;
            else led_prog = LedFail;
          end else if (tok_cnt == OnTok) begin
            want = (on_prog == 2'd0) ? CharO : CharN;
            if (on_prog < OnDone && c == want) on_prog++;
            else on_prog = OnFail;
          end else if (tok_cnt == PinTok && num_phase != PhDone) begin
            // read the pin by atoi rules, saturating the magnitude
            skip = 1'b0;
            if (num_phase == PhLead) begin
              if (c == CharSpace || (c >= CharTab && c <= CharCr)) begin
                skip = 1'b1;
              end else begin
                num_phase = PhDig;
                if (c == CharPlus || c == CharMinus) begin
                  num_neg = (c == CharMinus);
                  skip    = 1'b1;
                end
              end
            end
            if (!skip) begin
              if (c >= CharZero && c <= CharNine) begin
                pin_acc = pin_acc * 10 + (c - CharZero);
                if (pin_acc > AccMax) pin_acc = AccMax;
              end else begin
                num_phase = PhDone;
              end
            end
          end
        end
      end
    end else begin
      ans = '0;
      if (led_prog == LedDone) begin
        pin = third_seen ? pin_acc : 0;
        neg = third_seen && num_neg && (pin != 0);
        ans.turn_on = (on_prog == OnDone);
        if (!neg && pin < PORT_WIDTH) begin
          port_bits[pin] = ans.turn_on;
          ans.applied    = 1'b1;
          ans.pin_index  = PinW'(pin);
        end
      end
      ans.port_value = ValueW'(port_bits);
      port_answer_q.push_back(ans);
      restart_line();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    led_answer_t got;
    led_answer_t exp_ans;
    if (!rst_ni) begin
      port_bits = '0;
      restart_line();
      port_answer_q.delete();
    end else begin
      // compare the result word first: it never belongs to this edge's byte
      if (out_valid_i && !out_stall_i) begin
        got = {port_value_i, applied_i, pin_index_i, turn_on_i};
        if (port_answer_q.size() == 0) begin
          $display("%0t: unexpected result port %h applied %b pin %0d on %b",
                   $time, got.port_value, got.applied, got.pin_index, got.turn_on);
          fail_count_o++;
        end else begin
          exp_ans = port_answer_q.pop_front();
          if (got !== exp_ans) begin
            $display("%0t: result mismatch: expected port %h applied %b pin %0d on %b",
                     $time, exp_ans.port_value, exp_ans.applied, exp_ans.pin_index,
                     exp_ans.turn_on);
            $display("%0t:                   actual port %h applied %b pin %0d on %b",
                     $time, got.port_value, got.applied, got.pin_index, got.turn_on);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) parse_rx_byte(rx_byte_i);
    end
    pending_o = port_answer_q.size();
  end

endmodule

### dv/tb_led_text_command_parser_unit.sv
// ----------------------------------------------------------------------------
// tb_led_text_command_parser_unit
// Drives text lines into the LED text command parser: a directed set of
// command lines for the corner cases, then random lines that are mostly
// well-formed LED commands with noise, long and zero-byte lines mixed in.
// Both channels idle and stall at random; the checker judges every result.
// ----------------------------------------------------------------------------
module tb_led_text_command_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ltcp_pkg::*;

  localparam int unsigned RandomBytes = 1160;
  localparam int unsigned CycleLimit  = 600000;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ByteW-1:0]  rx_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ValueW-1:0] port_value;
  logic              applied;
  logic [PinW-1:0]   pin_index;
  logic              turn_on;
  int                mismatch_count;
  int                open_lines;

  logic [ByteW-1:0]  line_q[$];
  int unsigned       sent_count = 0;
  int unsigned       calm_left = 0;
  int unsigned       cycle_count = 0;

  led_text_command_parser_unit dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .rx_byte_i    (rx_byte),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .port_value_o (port_value),
    .applied_o    (applied),
    .pin_index_o  (pin_index),
    .turn_on_o    (turn_on)
  );

  ltcp_checker checker_u (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .rx_byte_i    (rx_byte),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .port_value_i (port_value),
    .applied_i    (applied),
    .pin_index_i  (pin_index),
    .turn_on_i    (turn_on),
    .fail_count_o (mismatch_count),
    .pending_o    (open_lines)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up after a generous number of cycles
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Stall the result channel in random stretches, with long calm periods
  initial begin
    int unsigned r;
    int unsigned len;
    logic        hold;
    @(negedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        hold = 1'b0;
        len  = $urandom_range(1, 12);
      end else if (r < 85) begin
        hold = 1'b1;
        len  = $urandom_range(1, 3);
      end else if (r < 95) begin
        hold = 1'b1;
        len  = $urandom_range(4, 30);
      end else begin
        hold = 1'b0;
        len  = $urandom_range(100, 300);
      end
      out_stall <= hold;
      repeat (len) @(negedge clk);
    end
  end

  // Offer one byte after a random idle gap and hold it until taken
  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    int unsigned r;
    gap = 0;
    if (calm_left > 0) begin
      calm_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) gap = 0;
      else if (r < 92) gap = $urandom_range(1, 3);
      else if (r < 99) gap = $urandom_range(4, 20);
      else gap = $urandom_range(21, 60);
      if ($urandom_range(0, 299) == 0) calm_left = $urandom_range(40, 150);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent_count++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i]);
    line_q.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  // Append n random token bytes: no zero, separator or carriage return
  task automatic add_token(input int unsigned n);
    logic [ByteW-1:0] c;
    repeat (n) begin
      do c = ByteW'($urandom_range(1, 255));
      while (c == CharCr || c == CharLBrack || c == CharAt || c == CharRBrack);
      line_q.push_back(c);
    end
  endtask

  task automatic add_seps();
    int unsigned n;
    int unsigned r;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
    repeat (n) begin
      r = $urandom_range(0, 2);
      line_q.push_back(r == 0 ? CharLBrack : (r == 1 ? CharAt : CharRBrack));
    end
  endtask

  task automatic send_text(input string s);
    add_text(s);
    line_q.push_back(CharCr);
    send_line();
  endtask

  // Build and send one random line, mostly a well-formed LED command
  task automatic send_random_line();
    int unsigned kind;
    int unsigned r;
    int unsigned v;
    kind = $urandom_range(0, 99);
    if (kind < 74) begin
      if ($urandom_range(0, 9) != 0) add_token($urandom_range(1, 4));
      if ($urandom_range(0, 7) != 0) add_seps();
      r = $urandom_range(0, 99);
      if (r < 85) add_text("LED");
      else if (r < 90) add_text("LE");
      else if (r < 94) add_text("LEDD");
      else if (r < 97) add_text("led");
      else add_token($urandom_range(1, 3));
      add_seps();
      r = $urandom_range(0, 99);
      if (r < 50) add_text("ON");
      else if (r < 75) add_text("OFF");
      else if (r < 85) add_text("O");
      else if (r < 92) add_text("ONN");
      else add_token($urandom_range(1, 3));
      if ($urandom_range(0, 9) != 0) begin
        add_seps();
        // leading white space, sign, digits, then maybe trailing junk
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            line_q.push_back(($urandom_range(0, 4) == 0) ? CharSpace
                                                          : ByteW'($urandom_range(9, 12)));
          end
        end
        r = $urandom_range(0, 99);
        if (r < 12) line_q.push_back(CharMinus);
        else if (r < 20) line_q.push_back(CharPlus);
        r = $urandom_range(0, 99);
        if (r < 75) v = $urandom_range(0, 15);
        else if (r < 92) v = $urandom_range(16, 300);
        else v = $urandom_range(301, 99999);
        if ($urandom_range(0, 9) == 0) add_text($sformatf("%03d", v));
        else add_text($sformatf("%0d", v));
        if ($urandom_range(0, 4) == 0) add_token($urandom_range(1, 3));
      end
      while ($urandom_range(0, 5) == 0) begin
        add_seps();
        add_token($urandom_range(1, 3));
      end
      if ($urandom_range(0, 7) == 0) add_seps();
    end else if (kind < 88) begin
      // raw noise, carriage returns included
      repeat ($urandom_range(1, 30)) line_q.push_back(ByteW'($urandom_range(0, 255)));
    end else if (kind < 95) begin
      // long line, command first or after a long token, maybe past the limit
      if ($urandom_range(0, 1) == 0) begin
        add_text("q[LED]ON]");
        add_text($sformatf("%0d", $urandom_range(0, 15)));
        add_token($urandom_range(55, 80));
      end else begin
        add_token($urandom_range(50, 80));
        add_text("[LED]ON]5");
      end
    end else begin
      // zero byte somewhere in a command
      if ($urandom_range(0, 1) != 0) add_text("x[LED]ON]");
      else add_text("x[LED]OFF]");
      add_text($sformatf("%0d", $urandom_range(0, 15)));
      line_q.insert($urandom_range(0, line_q.size()), CharNul);
    end
    line_q.push_back(CharCr);
    send_line();
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed lines: pin extremes, on and off, sign and size rules
    send_text("x[LED]ON]15");
    send_text("x@LED@ON@0");
    send_text("x[LED]OFF]15");
    send_text("]]ab[[LED@@ON");
    send_text("x[LED]OFF]-0");
    send_text("x[LED]ON] \t\n\v\f+7z");
    send_text("x[LED]ON]-3");
    send_text("x[LED]ON]16");
    send_text("x[LED]ON]99999");
    send_text("x[LEDX]ON]1");
    send_text("x[LED]ONX]9");
    send_text("");
    send_text("[@]");
    send_text("LED]ON]2");
    send_text("x[LED]ON]2]a]b]c");
    send_text("x[LED");
    // zero byte after the pin, then before the whole command
    add_text("x[LED]ON]1");
    line_q.push_back(CharNul);
    send_text("5");
    line_q.push_back(CharNul);
    send_text("x[LED]ON]3");
    // last digit sits exactly on the line limit, the next one is dropped
    add_text("x[LED]ON]");
    repeat (54) line_q.push_back(CharSpace);
    send_text("47");
    // top-bit byte in the first token
    line_q.push_back(8'hff);
    send_text("[LED]ON]11");

    // Random lines
    sent_count = 0;
    while (sent_count < RandomBytes) send_random_line();
    in_valid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    while (open_lines != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && open_lines == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/ltcp_pkg.sv
rtl/ltcp_line_parser.sv
rtl/ltcp_cmd_exec.sv
rtl/led_text_command_parser_unit.sv
dv/ltcp_checker.sv
dv/tb_led_text_command_parser_unit.sv
